>>> rtl/core/psrac_pkg.sv
// Package for the point scale/rotate block: widths, register indexes,
// sine quarter-wave table generator and fixed-point helpers. No dependencies.
package psrac_pkg;

  localparam int CoordW     = 32;
  localparam int WorkW      = 33;
  localparam int ScaleW     = 24;
  localparam int AngleW     = 16;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int DefTableDepth = 1024;
  localparam int DefTrigFrac   = 16;
  localparam logic [ScaleW-1:0] UnitScale = 24'd65536;

  localparam logic [CfgIdxW-1:0] RegCenterX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenterZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScale   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAngleX  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAngleY  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAngleZ  = 3'd6;

  // Saturate a 66-bit signed value to the 33-bit working range.
  function automatic logic signed [WorkW-1:0] sat_work(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd4294967295;
    lo = -66'sd4294967296;
    if (v > hi) sat_work = hi[WorkW-1:0];
    else if (v < lo) sat_work = lo[WorkW-1:0];
    else sat_work = v[WorkW-1:0];
  endfunction

  // Q60 multiply for the sine table entries, computed at elaboration from a Q60 Taylor series.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    mul_q60 = p[123:60];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract; table generation only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    udiv64 = quo;
  endfunction

  function automatic logic [31:0] sine_entry(input int k, input int depth, input int frac);
    logic [63:0] hp;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] one;
    int sh;
    hp = 64'h1921FB54442D1847;
    q = udiv64(hp, 64'(depth));
    r = hp - q * 64'(depth);
    x = q * 64'(k) + udiv64(r * 64'(k), 64'(depth));
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 13; n++) begin
      term = udiv64(mul_q60(term, x2), 64'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    sh = 60 - frac;
    one = 64'd1 << frac;
    v = (sum + (64'd1 << (sh - 1))) >> sh;
    sine_entry = (v > one) ? one[31:0] : v[31:0];
  endfunction

endpackage

>>> rtl/core/psrac_rot.sv
// One rotation stage pair: table lookup, products, then round and saturate
// (bypassed at angle zero). Depends on psrac_pkg. One item per cycle.
module psrac_rot import psrac_pkg::*; #(
  parameter int SINE_TABLE_DEPTH   = DefTableDepth,
  parameter int TRIG_FRACTION_BITS = DefTrigFrac
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [AngleW-1:0]       angle,
  input  logic                    in_valid,
  input  logic signed [WorkW-1:0] in_p,
  input  logic signed [WorkW-1:0] in_q,
  input  logic signed [WorkW-1:0] in_r,
  output logic                    out_valid,
  output logic signed [WorkW-1:0] out_p,
  output logic signed [WorkW-1:0] out_q,
  output logic signed [WorkW-1:0] out_r
);
  localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TrigW = TRIG_FRACTION_BITS + 2;
  localparam int ProdW = WorkW + TrigW;

  logic [TRIG_FRACTION_BITS:0] rom [SINE_TABLE_DEPTH+1];
  always_comb begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      rom[k] = (TRIG_FRACTION_BITS+1)'(sine_entry(k, SINE_TABLE_DEPTH, TRIG_FRACTION_BITS));
    end
  end

  function automatic logic signed [TrigW-1:0] lookup(input logic [AngleW-1:0] a);
    logic [1:0] quad;
    logic [IdxW+14:0] prod;
    logic [IdxW-1:0] i;
    logic signed [TrigW-1:0] v;
    quad = a[15:14];
    prod = (IdxW+15)'(a[13:0]) * (IdxW+15)'(SINE_TABLE_DEPTH) + (IdxW+15)'(8192);
    i = prod[IdxW+13:14];
    if (i > IdxW'(SINE_TABLE_DEPTH)) i = IdxW'(SINE_TABLE_DEPTH);
    if (quad[0]) i = IdxW'(SINE_TABLE_DEPTH) - i;
    v = TrigW'({1'b0, rom[i]});
    lookup = quad[1] ? -v : v;
  endfunction

  // stage A: trig lookup
  logic                    va;
  logic                    skip_a;
  logic signed [TrigW-1:0] s_a;
  logic signed [TrigW-1:0] c_a;
  logic signed [WorkW-1:0] p_a;
  logic signed [WorkW-1:0] q_a;
  logic signed [WorkW-1:0] r_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    skip_a <= (angle == '0);
    s_a <= lookup(angle);
    c_a <= lookup(angle + AngleW'(16384));
    p_a <= in_p;
    q_a <= in_q;
    r_a <= in_r;
  end

  // stage B: four products
  logic                    vb;
  logic                    skip_b;
  logic signed [ProdW-1:0] pc_b;
  logic signed [ProdW-1:0] qs_b;
  logic signed [ProdW-1:0] ps_b;
  logic signed [ProdW-1:0] qc_b;
  logic signed [WorkW-1:0] p_b;
  logic signed [WorkW-1:0] q_b;
  logic signed [WorkW-1:0] r_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    skip_b <= skip_a;
    pc_b <= ProdW'(p_a) * ProdW'(c_a);
    qs_b <= ProdW'(q_a) * ProdW'(s_a);
    ps_b <= ProdW'(p_a) * ProdW'(s_a);
    qc_b <= ProdW'(q_a) * ProdW'(c_a);
    p_b <= p_a;
    q_b <= q_a;
    r_b <= r_a;
  end

  // stage C: sum, round half up, saturate
  logic signed [ProdW:0] np;
  logic signed [ProdW:0] nq;
  logic signed [65:0] np_s;
  logic signed [65:0] nq_s;
  always_comb begin
    np = (ProdW+1)'(pc_b) - (ProdW+1)'(qs_b) + ((ProdW+1)'(1) <<< (TRIG_FRACTION_BITS-1));
    nq = (ProdW+1)'(ps_b) + (ProdW+1)'(qc_b) + ((ProdW+1)'(1) <<< (TRIG_FRACTION_BITS-1));
    np_s = 66'(np >>> TRIG_FRACTION_BITS);
    nq_s = 66'(nq >>> TRIG_FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vb;
    end
    out_p <= skip_b ? p_b : sat_work(np_s);
    out_q <= skip_b ? q_b : sat_work(nq_s);
    out_r <= r_b;
  end
endmodule

>>> rtl/core/point_scale_rotate_about_center.sv
// Top level of the point scale/rotate block: config registers, offset,
// scale, three rotations and output. Depends on psrac_pkg and psrac_rot.
//
// Point transform pipeline. Each start pulse with busy low enters one point
// (busy is always low, so a point may enter every cycle); the result comes
// out on out_x/out_y/out_z with done high, one result per cycle. The stage
// chain: offset (1), scale multiply and round (2), three rotations of three
// stages each (9), center add and saturate (2). The receiver cannot stall:
// sample results when done is high. The sine table is a constant
// quarter-wave table per rotation unit. Write configuration only while no
// point is in flight; cfg_ready is always high and unknown indexes are
// dropped.
module point_scale_rotate_about_center import psrac_pkg::*; #(
  parameter int SINE_TABLE_DEPTH   = DefTableDepth,
  parameter int TRIG_FRACTION_BITS = DefTrigFrac
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [CoordW-1:0]   in_x,
  input  logic signed [CoordW-1:0]   in_y,
  input  logic signed [CoordW-1:0]   in_z,
  output logic                       done,
  output logic signed [CoordW-1:0]   out_x,
  output logic signed [CoordW-1:0]   out_y,
  output logic signed [CoordW-1:0]   out_z,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data
);
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic signed [CoordW-1:0] center_z;
  logic [ScaleW-1:0]        scale_factor;
  logic [AngleW-1:0]        angle_x;
  logic [AngleW-1:0]        angle_y;
  logic [AngleW-1:0]        angle_z;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers: take the low bits, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      scale_factor <= UnitScale;
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegCenterX: center_x <= cfg_data;
        RegCenterY: center_y <= cfg_data;
        RegCenterZ: center_z <= cfg_data;
        RegScale:   scale_factor <= cfg_data[ScaleW-1:0];
        RegAngleX:  angle_x <= cfg_data[AngleW-1:0];
        RegAngleY:  angle_y <= cfg_data[AngleW-1:0];
        RegAngleZ:  angle_z <= cfg_data[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: subtract the pivot, exact in 33 bits.
  logic                    v1;
  logic signed [WorkW-1:0] x1;
  logic signed [WorkW-1:0] y1;
  logic signed [WorkW-1:0] z1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    x1 <= WorkW'(in_x) - WorkW'(center_x);
    y1 <= WorkW'(in_y) - WorkW'(center_y);
    z1 <= WorkW'(in_z) - WorkW'(center_z);
  end

  // Stage 2: scale products (33 x 25 signed).
  localparam int SProdW = WorkW + ScaleW + 1;
  logic                     v2;
  logic signed [SProdW-1:0] xs2;
  logic signed [SProdW-1:0] ys2;
  logic signed [SProdW-1:0] zs2;
  logic signed [WorkW-1:0]  x2;
  logic signed [WorkW-1:0]  y2;
  logic signed [WorkW-1:0]  z2;
  logic signed [SProdW-1:0] scale_s;
  assign scale_s = SProdW'({1'b0, scale_factor});
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    xs2 <= SProdW'(x1) * scale_s;
    ys2 <= SProdW'(y1) * scale_s;
    zs2 <= SProdW'(z1) * scale_s;
    x2 <= x1;
    y2 <= y1;
    z2 <= z1;
  end

  // Stage 3: round half up by 16 bits, saturate; bypass at unit scale.
  logic signed [SProdW-1:0] rnd_x;
  logic signed [SProdW-1:0] rnd_y;
  logic signed [SProdW-1:0] rnd_z;
  assign rnd_x = (xs2 + SProdW'(32768)) >>> 16;
  assign rnd_y = (ys2 + SProdW'(32768)) >>> 16;
  assign rnd_z = (zs2 + SProdW'(32768)) >>> 16;

  logic                    v3;
  logic signed [WorkW-1:0] x3;
  logic signed [WorkW-1:0] y3;
  logic signed [WorkW-1:0] z3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    if (scale_factor == UnitScale) begin
      x3 <= x2;
      y3 <= y2;
      z3 <= z2;
    end else begin
      x3 <= sat_work(66'(rnd_x));
      y3 <= sat_work(66'(rnd_y));
      z3 <= sat_work(66'(rnd_z));
    end
  end

  // Rotations: X on (y,z), Y on (z,x), Z on (x,y).
  logic                    vrx;
  logic signed [WorkW-1:0] ry_x;
  logic signed [WorkW-1:0] rz_x;
  logic signed [WorkW-1:0] rx_x;
  psrac_rot #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS))
    u_rot_x (.clk, .rst, .angle(angle_x), .in_valid(v3), .in_p(y3), .in_q(z3), .in_r(x3),
             .out_valid(vrx), .out_p(ry_x), .out_q(rz_x), .out_r(rx_x));

  logic                    vry;
  logic signed [WorkW-1:0] rz_y;
  logic signed [WorkW-1:0] rx_y;
  logic signed [WorkW-1:0] ry_y;
  psrac_rot #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS))
    u_rot_y (.clk, .rst, .angle(angle_y), .in_valid(vrx), .in_p(rz_x), .in_q(rx_x),
             .in_r(ry_x), .out_valid(vry), .out_p(rz_y), .out_q(rx_y), .out_r(ry_y));

  logic                    vrz;
  logic signed [WorkW-1:0] rx_z;
  logic signed [WorkW-1:0] ry_z;
  logic signed [WorkW-1:0] rz_z;
  psrac_rot #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS))
    u_rot_z (.clk, .rst, .angle(angle_z), .in_valid(vry), .in_p(rx_y), .in_q(ry_y),
             .in_r(rz_y), .out_valid(vrz), .out_p(rx_z), .out_q(ry_z), .out_r(rz_z));

  // Add the pivot back, then saturate to 32 bits.
  logic                    v4;
  logic signed [WorkW:0]   sx4;
  logic signed [WorkW:0]   sy4;
  logic signed [WorkW:0]   sz4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vrz;
    end
    sx4 <= (WorkW+1)'(rx_z) + (WorkW+1)'(center_x);
    sy4 <= (WorkW+1)'(ry_z) + (WorkW+1)'(center_y);
    sz4 <= (WorkW+1)'(rz_z) + (WorkW+1)'(center_z);
  end

  function automatic logic signed [CoordW-1:0] sat_out(input logic signed [WorkW:0] v);
    if (v > (WorkW+1)'(32'sh7FFFFFFF)) sat_out = 32'sh7FFFFFFF;
    else if (v < -(WorkW+1)'(34'sd2147483648)) sat_out = 32'sh80000000;
    else sat_out = v[CoordW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    out_x <= sat_out(sx4);
    out_y <= sat_out(sy4);
    out_z <= sat_out(sz4);
  end
endmodule

>>> tb/tb.sv
// Self-checking testbench for point_scale_rotate_about_center: drives points and
// register writes, predicts each transformed point and checks every result.
// Depends on psrac_pkg and the point_scale_rotate_about_center RTL.
`timescale 1ns / 100ps

module tb;
  import psrac_pkg::*;

  localparam int TableDepth = 1024;
  localparam int TrigFrac   = 16;
  localparam int Latency    = 14;
  localparam int DrainWait  = Latency + 4;
  localparam int StallLimit = 4000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [CoordW-1:0] in_x, in_y, in_z;
  logic done;
  logic signed [CoordW-1:0] out_x, out_y, out_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  point_scale_rotate_about_center dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the pivot, scale and angle registers.
  longint pivot_x, pivot_y, pivot_z;
  longint scale_q16;
  logic [AngleW-1:0] turn_x, turn_y, turn_z;

  longint sine_q [0:TableDepth];
  point_t expected_points[$];
  int errors;
  int idle_pct;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // (a*b) >> 60 on unsigned 64-bit operands.
  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  // Quarter-wave sine table, rounded to TrigFrac fraction bits.
  function automatic void fill_sine_table();
    logic [63:0] half_pi, q, r, x, x2, term, sum, v;
    half_pi = 64'h1921FB54442D1847;
    q = half_pi / TableDepth;
    r = half_pi % TableDepth;
    for (int k = 0; k <= TableDepth; k++) begin
      x = q * k + (r * k) / TableDepth;
      x2 = q60_product(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 13; n++) begin
        term = q60_product(term, x2) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      v = (sum + (64'd1 << (59 - TrigFrac))) >> (60 - TrigFrac);
      sine_q[k] = (v > (64'd1 << TrigFrac)) ? (longint'(1) << TrigFrac) : longint'(v);
    end
  endfunction

  function automatic longint sine_of(input logic [AngleW-1:0] a);
    int idx;
    longint v;
    idx = (int'(a[13:0]) * TableDepth + 8192) >> 14;
    if (idx > TableDepth) idx = TableDepth;
    if (a[14]) idx = TableDepth - idx;
    v = sine_q[idx];
    return a[15] ? -v : v;
  endfunction

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Round half toward plus infinity: arithmetic shift floors.
  function automatic longint shift_round(input longint p, input int sh);
    return (p + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // Rotate pair (p, q): p' = p*c - q*s, q' = p*s + q*c.
  function automatic void turn_pair(inout longint p, inout longint q,
                                    input logic [AngleW-1:0] a);
    longint s, c, np, nq;
    s = sine_of(a);
    c = sine_of(a + 16'd16384);
    np = shift_round(p * c - q * s, TrigFrac);
    nq = shift_round(p * s + q * c, TrigFrac);
    p = clamp_bits(np, WorkW);
    q = clamp_bits(nq, WorkW);
  endfunction

  function automatic point_t transform_point(input point_t pin);
    longint x, y, z;
    point_t r;
    x = longint'(pin.x) - pivot_x;
    y = longint'(pin.y) - pivot_y;
    z = longint'(pin.z) - pivot_z;
    if (scale_q16 != 65536) begin
      x = clamp_bits(shift_round(x * scale_q16, 16), WorkW);
      y = clamp_bits(shift_round(y * scale_q16, 16), WorkW);
      z = clamp_bits(shift_round(z * scale_q16, 16), WorkW);
    end
    if (turn_x != 0) turn_pair(y, z, turn_x);
    if (turn_y != 0) turn_pair(z, x, turn_y);
    if (turn_z != 0) turn_pair(x, y, turn_z);
    r.x = CoordW'(clamp_bits(x + pivot_x, CoordW));
    r.y = CoordW'(clamp_bits(y + pivot_y, CoordW));
    r.z = CoordW'(clamp_bits(z + pivot_z, CoordW));
    return r;
  endfunction

  function automatic void shadow_write(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] data);
    case (idx)
      RegCenterX: pivot_x = longint'($signed(data));
      RegCenterY: pivot_y = longint'($signed(data));
      RegCenterZ: pivot_z = longint'($signed(data));
      RegScale:   scale_q16 = longint'(data[ScaleW-1:0]);
      RegAngleX:  turn_x = data[AngleW-1:0];
      RegAngleY:  turn_y = data[AngleW-1:0];
      RegAngleZ:  turn_z = data[AngleW-1:0];
      default: ;
    endcase
  endfunction

  // Write one register; hold valid until the channel takes the transaction.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send one point, idling at random first; predict it on acceptance.
  task automatic send_point(input point_t p);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < idle_pct) begin
        start = 1'b0;
        continue;
      end
      start = 1'b1;
      in_x = p.x;
      in_y = p.y;
      in_z = p.z;
      do @(posedge clk); while (busy);
      expected_points.push_back(transform_point(p));
      break;
    end
  endtask

  // Drop start and wait until every result has come, plus a wait longer than the pipeline depth.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return CoordW'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t pick_point();
    point_t p;
    p.x = pick_coord();
    p.y = pick_coord();
    p.z = pick_coord();
    return p;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 32'd65536;
      1: return 32'd0;
      2: return 32'h00FF_FFFF;
      3: return $urandom;                       // upper byte must be dropped
      default: return $urandom_range(0, 200000);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;                          // rounds to table index zero
      2: return 32'd16384 * $urandom_range(0, 3);
      3: return $urandom;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_center();
    if ($urandom_range(0, 3) == 0) return pick_coord();
    return CoordW'($signed($urandom_range(0, 4000000)) - 2000000);
  endfunction

  task automatic load_settings(input logic [CfgDataW-1:0] cx, input logic [CfgDataW-1:0] cy,
                               input logic [CfgDataW-1:0] cz, input logic [CfgDataW-1:0] sc,
                               input logic [CfgDataW-1:0] ax, input logic [CfgDataW-1:0] ay,
                               input logic [CfgDataW-1:0] az);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegCenterZ, cz);
    write_reg(RegScale, sc);
    write_reg(RegAngleX, ax);
    write_reg(RegAngleY, ay);
    write_reg(RegAngleZ, az);
  endtask

  // Reset values: identity transform, field extremes pass straight through.
  task automatic test_reset_identity();
    point_t p;
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
    send_point(p);
    p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    send_point(p);
    send_point(pick_point());
    drain();
  endtask

  // Zero, full-range and truncated scale with extreme pivots.
  task automatic test_scale_cases();
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678});
    drain();
    write_reg(RegScale, 32'hFFFF_FFFF);        // excess bits drop to 24'hFFFFFF
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    send_point('{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000});
    drain();
    write_reg(RegScale, 32'd32768);
    send_point('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003});
    drain();
  endtask

  // Each axis alone, every quadrant boundary, a tiny angle and the top angle.
  task automatic test_rotations();
    logic [CfgDataW-1:0] angs[5];
    angs = '{32'd1, 32'd16384, 32'd32768, 32'd49152, 32'hFFFF_FFFF};
    load_settings(32'h0001_0000, 32'hFFFE_0000, 32'h0000_4000, 32'd65536, 0, 0, 0);
    for (int a = 0; a < 3; a++) begin
      write_reg(RegAngleX + CfgIdxW'(a), angs[a]);
      send_point('{32'h0003_0000, 32'h0005_8000, 32'hFFF9_0000});
      drain();
      write_reg(RegAngleX + CfgIdxW'(a), 32'd0);
    end
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF,
                  angs[3], angs[4], 32'd8192);
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_point(pick_point());
    drain();
  endtask

  // A write to an unused index must not disturb any register.
  task automatic test_unused_index();
    write_reg(RegUnused, $urandom);
    send_point(pick_point());
    send_point(pick_point());
    drain();
  endtask

  // Random settings and points; pause now and then until the pipe is empty.
  task automatic test_random_phase(input int pct, input int settings, input int per_setting);
    idle_pct = pct;
    for (int s = 0; s < settings; s++) begin
      load_settings(pick_center(), pick_center(), pick_center(), pick_scale(),
                    pick_angle(), pick_angle(), pick_angle());
      if ($urandom_range(0, 3) == 0) write_reg(RegUnused, $urandom);
      for (int i = 0; i < per_setting; i++) begin
        if ($urandom_range(0, 39) == 0) drain();
        send_point(pick_point());
      end
      drain();
    end
  endtask

  // Compare each strobed result against the oldest prediction.
  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x, out_y, out_z);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_x !== want.x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, out_x);
          errors++;
        end
        if (out_y !== want.y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, out_y);
          errors++;
        end
        if (out_z !== want.z) begin
          $display("%0t: out_z expected %h actual %h", $time, want.z, out_z);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAIL point_scale_rotate_about_center");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    idle_pct = 0;
    stall_cycles = 0;
    pivot_x = 0;
    pivot_y = 0;
    pivot_z = 0;
    scale_q16 = 65536;
    turn_x = '0;
    turn_y = '0;
    turn_z = '0;
    fill_sine_table();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_identity();
    test_scale_cases();
    test_rotations();
    test_unused_index();
    // Sender idles 14% of cycles, then 58%, then never.
    test_random_phase(14, 5, 30);
    test_random_phase(58, 5, 30);
    test_random_phase(0, 5, 30);

    drain();
    if (errors == 0) begin
      $display("PASS point_scale_rotate_about_center");
    end else begin
      $display("FAIL point_scale_rotate_about_center");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/psrac_pkg.sv
rtl/core/psrac_rot.sv
rtl/core/point_scale_rotate_about_center.sv
tb/tb.sv
